// ----- hdl/c2p_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, item types and the arctangent table of the cartesian-to-polar pipeline.
package c2p_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int ANGLE_WIDTH      = 16;
	localparam int ACC_WIDTH        = 32;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 32;
	localparam int FRAC_SHIFT       = 60 - COORD_WIDTH;
	localparam int ROT_WIDTH        = 63;
	localparam int SQ_WIDTH         = 2 * COORD_WIDTH;
	localparam int TRIAL_WIDTH      = SQ_WIDTH + 2;

	localparam logic [ACC_WIDTH-1:0] Z_PLUS_HALF_PI  = 32'h4000_0000;
	localparam logic [ACC_WIDTH-1:0] Z_MINUS_HALF_PI = 32'hC000_0000;
	localparam logic [ACC_WIDTH-1:0] ANGLE_ROUND     = 32'h0000_8000;

	// round(atan(2^-i) * 2^31 / pi)
	localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
	} c2p_in_t;

	typedef struct packed {
		logic        [COORD_WIDTH-1:0] magnitude;
		logic signed [ANGLE_WIDTH-1:0] angle;
	} c2p_out_t;

	typedef struct packed {
		logic signed [ROT_WIDTH-1:0] rot_x;
		logic signed [ROT_WIDTH-1:0] rot_y;
		logic        [ACC_WIDTH-1:0] z;
		logic                        origin;
		logic        [SQ_WIDTH-1:0]  rem;
		logic        [COORD_WIDTH-1:0] root;
	} c2p_stage_t;

endpackage

// ----- hdl/cartesian_to_polar_top.sv -----
`timescale 1ns / 1ps
// Top level of the cartesian-to-polar converter: input stages, iteration chain, output skid.
//
// Converts a point (x_coord, y_coord) into its rounded distance from the origin and its
// angle atan2(y, x) in binary angle units (32768 is pi, +pi reads as -32768; the origin
// gives 0 and 0). One item is taken every clock while point_stall is low; the chain is fully
// unrolled, three input stages (pre-rotation and absolute values, squaring, sum of squares)
// are followed by max(CORDIC_STEPS, 16) iteration stages, the first CORDIC_STEPS holding a
// CORDIC micro-rotation and the first 16 a square-root digit, and by the output register.
// The magnitude is exact (integer square root), not a CORDIC-gain estimate. Output
// back-pressure freezes the chain once a leaving item has been caught in a one-item skid
// register; nothing is dropped or repeated.
module cartesian_to_polar_top
	import c2p_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     point_valid,
	output logic     point_stall,
	input  c2p_in_t  point,
	output logic     polar_valid,
	input  logic     polar_stall,
	output c2p_out_t polar
);

	localparam int ITER_STAGES = (CORDIC_STEPS > COORD_WIDTH) ? CORDIC_STEPS : COORD_WIDTH;

	logic en;

	// Pre-rotation and absolute values.
	logic signed [ROT_WIDTH-1:0]   px;
	logic signed [ROT_WIDTH-1:0]   py;
	logic signed [ROT_WIDTH-1:0]   rx;
	logic signed [ROT_WIDTH-1:0]   ry;
	logic [ACC_WIDTH-1:0]          rz;
	logic signed [COORD_WIDTH:0]   xw;
	logic signed [COORD_WIDTH:0]   yw;
	logic signed [COORD_WIDTH:0]   axw;
	logic signed [COORD_WIDTH:0]   ayw;

	logic                          valid_s1;
	logic signed [ROT_WIDTH-1:0]   rx_s1;
	logic signed [ROT_WIDTH-1:0]   ry_s1;
	logic [ACC_WIDTH-1:0]          rz_s1;
	logic                          org_s1;
	logic [COORD_WIDTH-1:0]        ax_s1;
	logic [COORD_WIDTH-1:0]        ay_s1;

	logic                          valid_s2;
	logic signed [ROT_WIDTH-1:0]   rx_s2;
	logic signed [ROT_WIDTH-1:0]   ry_s2;
	logic [ACC_WIDTH-1:0]          rz_s2;
	logic                          org_s2;
	logic [SQ_WIDTH-1:0]           sqx_s2;
	logic [SQ_WIDTH-1:0]           sqy_s2;

	logic                          valid_s3;
	c2p_stage_t                    stage_s3;

	logic                          vld_w [0:ITER_STAGES];
	c2p_stage_t                    st_w  [0:ITER_STAGES];

	c2p_stage_t                    fin;
	logic                          fin_valid;
	logic                          round_up;
	logic [ACC_WIDTH-1:0]          angle_sum;
	c2p_out_t                      res;

	logic                          out_valid_q;
	c2p_out_t                      out_data_q;
	logic                          skid_valid_q;
	c2p_out_t                      skid_data_q;
	logic                          out_free;

	assign en          = !skid_valid_q;
	assign point_stall = skid_valid_q;

	always_comb begin
		px  = {{(ROT_WIDTH-COORD_WIDTH){point.x_coord[COORD_WIDTH-1]}}, point.x_coord}
			<<< FRAC_SHIFT;
		py  = {{(ROT_WIDTH-COORD_WIDTH){point.y_coord[COORD_WIDTH-1]}}, point.y_coord}
			<<< FRAC_SHIFT;
		xw  = {point.x_coord[COORD_WIDTH-1], point.x_coord};
		yw  = {point.y_coord[COORD_WIDTH-1], point.y_coord};
		axw = xw[COORD_WIDTH] ? -xw : xw;
		ayw = yw[COORD_WIDTH] ? -yw : yw;
		rx  = px;
		ry  = py;
		rz  = '0;
		// A point in the left half plane is turned by a quarter turn first.
		if (px[ROT_WIDTH-1]) begin
			if (!py[ROT_WIDTH-1]) begin
				rx = py;
				ry = -px;
				rz = Z_PLUS_HALF_PI;
			end else begin
				rx = -py;
				ry = px;
				rz = Z_MINUS_HALF_PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= point_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1  <= rx;
			ry_s1  <= ry;
			rz_s1  <= rz;
			org_s1 <= (point.x_coord == '0) && (point.y_coord == '0);
			ax_s1  <= axw[COORD_WIDTH-1:0];
			ay_s1  <= ayw[COORD_WIDTH-1:0];

			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;
			rz_s2  <= rz_s1;
			org_s2 <= org_s1;
			sqx_s2 <= SQ_WIDTH'(ax_s1) * SQ_WIDTH'(ax_s1);
			sqy_s2 <= SQ_WIDTH'(ay_s1) * SQ_WIDTH'(ay_s1);

			stage_s3.rot_x  <= rx_s2;
			stage_s3.rot_y  <= ry_s2;
			stage_s3.z      <= rz_s2;
			stage_s3.origin <= org_s2;
			stage_s3.rem    <= sqx_s2 + sqy_s2;
			stage_s3.root   <= '0;
		end
	end

	assign vld_w[0] = valid_s3;
	assign st_w[0]  = stage_s3;

	for (genvar j = 0; j < ITER_STAGES; j++) begin : g_iter
		c2p_iter #(
			.ROT_EN  (j < CORDIC_STEPS),
			.ROT_IDX ((j < CORDIC_STEPS) ? j : 0),
			.SQ_EN   (j < COORD_WIDTH),
			.SQ_BIT  ((j < COORD_WIDTH) ? (COORD_WIDTH - 1 - j) : 0)
		) u_iter (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (vld_w[j]),
			.stage   (st_w[j]),
			.valid_q (vld_w[j+1]),
			.stage_q (st_w[j+1])
		);
	end

	assign fin       = st_w[ITER_STAGES];
	assign fin_valid = vld_w[ITER_STAGES];

	always_comb begin
		round_up      = SQ_WIDTH'(fin.root) < fin.rem;
		angle_sum     = fin.z + ANGLE_ROUND;
		res.magnitude = fin.root + COORD_WIDTH'(round_up);
		res.angle     = fin.origin ? '0 : signed'(angle_sum[ACC_WIDTH-1 -: ANGLE_WIDTH]);
	end

	// The skid register catches the item that leaves the chain in the cycle the output stalls.
	assign out_free = !out_valid_q || !polar_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || fin_valid;
			skid_valid_q <= 1'b0;
		end else if (en && fin_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (en) begin
			skid_data_q <= res;
		end
	end

	assign polar_valid = out_valid_q;
	assign polar       = out_data_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !polar_stall) |=> (out_valid_q && !skid_valid_q))
		else $error("skid item did not move to the output register");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && polar_stall) |=> (skid_valid_q && $stable(skid_data_q)))
		else $error("skid item changed while the output was stalled");

	a_root_exact: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> (fin.rem <= SQ_WIDTH'({fin.root, 1'b0})))
		else $error("square-root remainder exceeds twice the root");

	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid && fin.origin) |-> (fin.root == '0) && (fin.rem == '0))
		else $error("origin item produced a nonzero magnitude");

endmodule

// ----- hdl/c2p_iter.sv -----
`timescale 1ns / 1ps
// One pipeline stage: a CORDIC micro-rotation and one digit of the integer square root, each enabled by a parameter.
module c2p_iter
	import c2p_pkg::*;
#(
	parameter bit ROT_EN  = 1'b1,
	parameter int ROT_IDX = 0,
	parameter bit SQ_EN   = 1'b1,
	parameter int SQ_BIT  = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid,
	input  c2p_stage_t stage,
	output logic       valid_q,
	output c2p_stage_t stage_q
);

	c2p_stage_t                  nxt;
	logic signed [ROT_WIDTH-1:0] dx;
	logic signed [ROT_WIDTH-1:0] dy;
	logic [TRIAL_WIDTH-1:0]      trial;

	always_comb begin
		nxt   = stage;
		dx    = stage.rot_y >>> ROT_IDX;
		dy    = stage.rot_x >>> ROT_IDX;
		// Root bits below SQ_BIT are still zero, so the shifted root and the
		// square of the new bit never overlap.
		trial = (TRIAL_WIDTH'(stage.root) << (SQ_BIT + 1)) |
			(TRIAL_WIDTH'(1) << (2 * SQ_BIT));
		if (ROT_EN) begin
			if (!stage.rot_y[ROT_WIDTH-1]) begin
				nxt.rot_x = stage.rot_x + dx;
				nxt.rot_y = stage.rot_y - dy;
				nxt.z     = stage.z + ATAN_TABLE[ROT_IDX];
			end else begin
				nxt.rot_x = stage.rot_x - dx;
				nxt.rot_y = stage.rot_y + dy;
				nxt.z     = stage.z - ATAN_TABLE[ROT_IDX];
			end
		end
		if (SQ_EN) begin
			if ({2'b00, stage.rem} >= trial) begin
				nxt.rem  = stage.rem - trial[SQ_WIDTH-1:0];
				nxt.root = stage.root | (COORD_WIDTH'(1) << SQ_BIT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

endmodule
